### hdl/zbpa_pkg.sv
// ----------------------------------------------------------------------------
// zbpa_pkg
// Types and constants shared by the zoned bitmap page allocator.
// ----------------------------------------------------------------------------
package zbpa_pkg;

  localparam int PAGES         = 65536;
  localparam int PAGE_SHIFT    = 12;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = PAGES / MAP_WORD_BITS;
  localparam int WADDR_W       = $clog2(MAP_WORDS);
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int PFN_W         = 18;
  localparam int CNT_W         = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] CMD_ALLOC     = 2'd0;
  localparam logic [1:0] CMD_FREE      = 2'd1;
  localparam logic [1:0] CMD_MARK_FREE = 2'd2;
  localparam logic [1:0] CMD_MARK_USED = 2'd3;

  localparam logic [1:0] ZSEL_DMA  = 2'd0;
  localparam logic [1:0] ZSEL_NRM  = 2'd1;
  localparam logic [1:0] ZSEL_HIGH = 2'd2;
  localparam logic [1:0] ZSEL_ANY  = 2'd3;

  localparam logic [1:0] REG_TOTAL   = 2'd0;
  localparam logic [1:0] REG_DMA_END = 2'd1;
  localparam logic [1:0] REG_NRM_END = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_FILL, S_FREE, S_MARK,
    S_WBACK, S_READ, S_LOAD, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [27:0] addr;
    logic [28:0] byte_size;
    logic [16:0] page_count;
    logic [1:0]  zone_sel;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [27:0] alloc_addr;
    logic [16:0] pages_changed;
    logic        bad_page_seen;
    logic        double_free_seen;
    logic [16:0] free_total;
    logic [16:0] usable_total;
    logic [16:0] free_dma;
    logic [16:0] free_normal;
    logic [16:0] free_high;
  } rsp_t;

endpackage

### hdl/zoned_bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// zoned_bitmap_page_allocator
// First-fit page allocator over a used-page bitmap split into three zones.
// Walks the bitmap page by page, fetching a bitmap word (after writing back
// a dirty buffered word) whenever a page lies in a word not yet buffered.
// One request at a time; busy is high until done.
// Reset: a sweep sets the bitmap to all used; busy stays high until it ends.
// Results show for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module zoned_bitmap_page_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  zbpa_pkg::req_t       req,
  output logic                 done,
  output zbpa_pkg::rsp_t       rsp,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [16:0]          cfg_data
);

  localparam int PW = zbpa_pkg::PFN_W;
  localparam int CW = zbpa_pkg::CNT_W;
  localparam int AW = zbpa_pkg::WADDR_W;
  localparam int BW = zbpa_pkg::BIT_W;
  localparam int MB = zbpa_pkg::MAP_WORD_BITS;
  localparam logic [AW-1:0] LAST_WORD = AW'(zbpa_pkg::MAP_WORDS - 1);
  localparam logic [29:0] PAGE_RND = 30'((1 << zbpa_pkg::PAGE_SHIFT) - 1);

  zbpa_pkg::state_t state, state_next, ret;

  logic [MB-1:0] mem [zbpa_pkg::MAP_WORDS];
  logic [MB-1:0] rdata, wbuf;
  logic [AW-1:0] widx, clr_idx;
  logic          wvalid, wdirty;

  logic [CW-1:0] total_reg, dma_end_reg, nrm_end_reg;
  logic [CW-1:0] zd, zn, zt;
  logic [CW-1:0] cnt_dma, cnt_nrm, cnt_high, cnt_all, cnt_usable;

  logic [1:0]    cmd;
  logic [1:0]    zsel;
  logic [1:0]    try_idx;
  logic [CW-1:0] count;
  logic [PW-1:0] cur, rem;
  logic [CW-1:0] mend;
  logic [CW-1:0] run_len, run_start, fill_end;
  logic          status, bad, dbl;
  logic [CW-1:0] changed;
  logic [27:0]   aaddr;

  // zone bounds from registers
  logic [CW-1:0] t_c, d_c, n_c;
  always_comb begin
    t_c = (total_reg > CW'(zbpa_pkg::PAGES)) ? CW'(zbpa_pkg::PAGES) : total_reg;
    d_c = (dma_end_reg < t_c) ? dma_end_reg : t_c;
    n_c = (nrm_end_reg < t_c) ? nrm_end_reg : t_c;
    if (n_c < d_c) n_c = d_c;
  end

  // region bounds at accept
  logic [29:0] last_b, s_rnd, e_rnd;
  logic [PW-1:0] m_start;
  logic [18:0]   m_end;
  always_comb begin
    last_b = 30'(req.addr) + 30'(req.byte_size);
    s_rnd  = 30'(req.addr) + PAGE_RND;
    e_rnd  = last_b + PAGE_RND;
    if (req.cmd == zbpa_pkg::CMD_MARK_FREE) begin
      m_start = PW'(s_rnd >> zbpa_pkg::PAGE_SHIFT);
      m_end   = 19'(last_b >> zbpa_pkg::PAGE_SHIFT);
    end else begin
      m_start = PW'(req.addr >> zbpa_pkg::PAGE_SHIFT);
      m_end   = 19'(e_rnd >> zbpa_pkg::PAGE_SHIFT);
    end
  end

  // current zone under allocation
  logic [1:0]    azone;
  logic          try_last;
  logic [CW-1:0] zlo, zhi, zcnt;
  always_comb begin
    if (zsel == zbpa_pkg::ZSEL_ANY) begin
      case (try_idx)
        2'd0:    azone = zbpa_pkg::ZSEL_NRM;
        2'd1:    azone = zbpa_pkg::ZSEL_HIGH;
        default: azone = zbpa_pkg::ZSEL_DMA;
      endcase
      try_last = (try_idx == 2'd2);
    end else begin
      azone    = zsel;
      try_last = 1'b1;
    end
    case (azone)
      zbpa_pkg::ZSEL_DMA: begin zlo = '0; zhi = zd; zcnt = cnt_dma;  end
      zbpa_pkg::ZSEL_NRM: begin zlo = zd; zhi = zn; zcnt = cnt_nrm;  end
      default:            begin zlo = zn; zhi = zt; zcnt = cnt_high; end
    endcase
  end

  logic          hit, cur_used, in_dma, in_nrm;
  logic [CW-1:0] rs, run_next;
  assign hit      = wvalid && (widx == cur[BW +: AW]);
  assign cur_used = wbuf[cur[BW-1:0]];
  assign in_dma   = cur < PW'(zd);
  assign in_nrm   = cur < PW'(zn);
  assign rs       = (run_len == '0) ? CW'(cur) : run_start;
  assign run_next = run_len + 1'b1;

  // memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MB-1:0] mem_wdata;
  always_comb begin
    mem_we    = (state == zbpa_pkg::S_CLEAR) || (state == zbpa_pkg::S_WBACK);
    mem_waddr = (state == zbpa_pkg::S_CLEAR) ? clr_idx : widx;
    mem_wdata = (state == zbpa_pkg::S_CLEAR) ? '1 : wbuf;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[cur[BW +: AW]];
  end

  // next state
  always_comb begin
    state_next = state;
    busy = (state != zbpa_pkg::S_IDLE);
    done = (state == zbpa_pkg::S_DONE);
    case (state)
      zbpa_pkg::S_CLEAR: if (clr_idx == LAST_WORD) state_next = zbpa_pkg::S_IDLE;
      zbpa_pkg::S_IDLE: begin
        if (start) begin
          case (req.cmd)
            zbpa_pkg::CMD_ALLOC: state_next = zbpa_pkg::S_CHECK;
            zbpa_pkg::CMD_FREE:  state_next = zbpa_pkg::S_FREE;
            default:             state_next = zbpa_pkg::S_MARK;
          endcase
        end
      end
      zbpa_pkg::S_CHECK: begin
        if (count == '0 || zcnt < count) begin
          if (try_last) state_next = zbpa_pkg::S_DONE;
        end else begin
          state_next = zbpa_pkg::S_SCAN;
        end
      end
      zbpa_pkg::S_SCAN: begin
        if (cur >= PW'(zhi)) state_next = try_last ? zbpa_pkg::S_DONE : zbpa_pkg::S_CHECK;
        else if (!hit) state_next = wdirty ? zbpa_pkg::S_WBACK : zbpa_pkg::S_READ;
        else if (!cur_used && run_next == count) state_next = zbpa_pkg::S_FILL;
      end
      zbpa_pkg::S_FILL: begin
        if (!hit) state_next = wdirty ? zbpa_pkg::S_WBACK : zbpa_pkg::S_READ;
        else if (CW'(cur) + 1'b1 == fill_end) state_next = zbpa_pkg::S_DONE;
      end
      zbpa_pkg::S_FREE: begin
        if (rem == '0) state_next = zbpa_pkg::S_DONE;
        else if (cur < PW'(zt) && !hit)
          state_next = wdirty ? zbpa_pkg::S_WBACK : zbpa_pkg::S_READ;
      end
      zbpa_pkg::S_MARK: begin
        if (cur >= PW'(mend)) state_next = zbpa_pkg::S_DONE;
        else if (!hit) state_next = wdirty ? zbpa_pkg::S_WBACK : zbpa_pkg::S_READ;
      end
      zbpa_pkg::S_WBACK: state_next = zbpa_pkg::S_READ;
      zbpa_pkg::S_READ:  state_next = zbpa_pkg::S_LOAD;
      zbpa_pkg::S_LOAD:  state_next = ret;
      zbpa_pkg::S_DONE:  state_next = zbpa_pkg::S_IDLE;
      default:           state_next = zbpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= zbpa_pkg::S_CLEAR;
    else     state <= state_next;
  end

  // saturating counter updates
  function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] c);
    return (c == zbpa_pkg::CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [CW-1:0] sub_sat(input logic [CW-1:0] c,
                                            input logic [CW-1:0] v);
    return (c > v) ? c - v : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx     <= '0;
      wvalid      <= 1'b0;
      wdirty      <= 1'b0;
      total_reg   <= 17'd65536;
      dma_end_reg <= 17'd4096;
      nrm_end_reg <= 17'd65536;
      cnt_dma     <= '0;
      cnt_nrm     <= '0;
      cnt_high    <= '0;
      cnt_all     <= '0;
      cnt_usable  <= '0;
      ret         <= zbpa_pkg::S_IDLE;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          zbpa_pkg::REG_TOTAL:   total_reg   <= cfg_data;
          zbpa_pkg::REG_DMA_END: dma_end_reg <= cfg_data;
          zbpa_pkg::REG_NRM_END: nrm_end_reg <= cfg_data;
          default: ;
        endcase
      end
      if ((state == zbpa_pkg::S_SCAN || state == zbpa_pkg::S_FILL ||
           state == zbpa_pkg::S_FREE || state == zbpa_pkg::S_MARK) &&
          (state_next == zbpa_pkg::S_WBACK || state_next == zbpa_pkg::S_READ))
        ret <= state;
      case (state)
        zbpa_pkg::S_CLEAR: clr_idx <= clr_idx + 1'b1;
        zbpa_pkg::S_IDLE: begin
          if (start) begin
            zd      <= d_c;
            zn      <= n_c;
            zt      <= t_c;
            cmd     <= req.cmd;
            zsel    <= req.zone_sel;
            count   <= req.page_count;
            try_idx <= '0;
            status  <= 1'b0;
            bad     <= 1'b0;
            dbl     <= 1'b0;
            changed <= '0;
            aaddr   <= '0;
            rem     <= PW'(req.page_count);
            mend    <= (m_end > 19'(t_c)) ? t_c : CW'(m_end);
            if (req.cmd == zbpa_pkg::CMD_FREE)
              cur <= PW'(req.addr >> zbpa_pkg::PAGE_SHIFT);
            else
              cur <= m_start;
          end
        end
        zbpa_pkg::S_CHECK: begin
          cur     <= PW'(zlo);
          run_len <= '0;
          if (count == '0 || zcnt < count) begin
            try_idx <= try_idx + 1'b1;
            if (try_last) status <= 1'b1;
          end
        end
        zbpa_pkg::S_SCAN: begin
          if (cur >= PW'(zhi)) begin
            try_idx <= try_idx + 1'b1;
            if (try_last) status <= 1'b1;
          end else if (hit) begin
            if (cur_used) begin
              run_len <= '0;
              cur     <= cur + 1'b1;
            end else if (run_next == count) begin
              run_start <= rs;
              fill_end  <= rs + count;
              cur       <= PW'(rs);
            end else begin
              run_start <= rs;
              run_len   <= run_next;
              cur       <= cur + 1'b1;
            end
          end
        end
        zbpa_pkg::S_FILL: begin
          if (hit) begin
            wbuf[cur[BW-1:0]] <= 1'b1;
            wdirty <= 1'b1;
            cur    <= cur + 1'b1;
            if (CW'(cur) + 1'b1 == fill_end) begin
              aaddr   <= 28'({run_start, {zbpa_pkg::PAGE_SHIFT{1'b0}}});
              changed <= count;
              cnt_all <= sub_sat(cnt_all, count);
              case (azone)
                zbpa_pkg::ZSEL_DMA: cnt_dma  <= sub_sat(cnt_dma, count);
                zbpa_pkg::ZSEL_NRM: cnt_nrm  <= sub_sat(cnt_nrm, count);
                default:            cnt_high <= sub_sat(cnt_high, count);
              endcase
            end
          end
        end
        zbpa_pkg::S_FREE: begin
          if (rem != '0) begin
            if (cur >= PW'(zt)) begin
              bad <= 1'b1;
              cur <= cur + 1'b1;
              rem <= rem - 1'b1;
            end else if (hit) begin
              cur <= cur + 1'b1;
              rem <= rem - 1'b1;
              if (!cur_used) begin
                dbl <= 1'b1;
              end else begin
                wbuf[cur[BW-1:0]] <= 1'b0;
                wdirty  <= 1'b1;
                cnt_all <= inc_sat(cnt_all);
                changed <= inc_sat(changed);
                if (in_dma)      cnt_dma  <= inc_sat(cnt_dma);
                else if (in_nrm) cnt_nrm  <= inc_sat(cnt_nrm);
                else             cnt_high <= inc_sat(cnt_high);
              end
            end
          end
        end
        zbpa_pkg::S_MARK: begin
          if (cur < PW'(mend) && hit) begin
            cur <= cur + 1'b1;
            if (cmd == zbpa_pkg::CMD_MARK_FREE && cur_used) begin
              wbuf[cur[BW-1:0]] <= 1'b0;
              wdirty     <= 1'b1;
              cnt_all    <= inc_sat(cnt_all);
              cnt_usable <= inc_sat(cnt_usable);
              changed    <= inc_sat(changed);
              if (in_dma)      cnt_dma  <= inc_sat(cnt_dma);
              else if (in_nrm) cnt_nrm  <= inc_sat(cnt_nrm);
              else             cnt_high <= inc_sat(cnt_high);
            end else if (cmd == zbpa_pkg::CMD_MARK_USED && !cur_used) begin
              wbuf[cur[BW-1:0]] <= 1'b1;
              wdirty  <= 1'b1;
              cnt_all <= sub_sat(cnt_all, CW'(1));
              changed <= inc_sat(changed);
              if (in_dma)      cnt_dma  <= sub_sat(cnt_dma, CW'(1));
              else if (in_nrm) cnt_nrm  <= sub_sat(cnt_nrm, CW'(1));
              else             cnt_high <= sub_sat(cnt_high, CW'(1));
            end
          end
        end
        zbpa_pkg::S_WBACK: wdirty <= 1'b0;
        zbpa_pkg::S_LOAD: begin
          wbuf   <= rdata;
          widx   <= cur[BW +: AW];
          wvalid <= 1'b1;
          wdirty <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rsp.status           = status;
    rsp.alloc_addr       = aaddr;
    rsp.pages_changed    = changed;
    rsp.bad_page_seen    = bad;
    rsp.double_free_seen = dbl;
    rsp.free_total       = cnt_all;
    rsp.usable_total     = cnt_usable;
    rsp.free_dma         = cnt_dma;
    rsp.free_normal      = cnt_nrm;
    rsp.free_high        = cnt_high;
  end

endmodule

### tb/zoned_bitmap_page_allocator_test.sv
// ----------------------------------------------------------------------------
// zoned_bitmap_page_allocator_test
// Drives allocate, free and region requests through several zone layouts and
// checks every response against a bitmap predictor kept in the testbench.
// ----------------------------------------------------------------------------
module zoned_bitmap_page_allocator_test;

  localparam int  CYCLE_LIMIT = 8000000;
  localparam int  SHOW_LIMIT  = 10;
  localparam int  PAGE_BYTES  = 1 << zbpa_pkg::PAGE_SHIFT;
  localparam int  NO_ZONE     = 3;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  zbpa_pkg::req_t  req;
  logic            done;
  zbpa_pkg::rsp_t  rsp;
  logic            cfg_we;
  logic [1:0]      cfg_idx;
  logic [16:0]     cfg_data;

  zoned_bitmap_page_allocator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  // Predictor state
  bit   page_used_q [zbpa_pkg::PAGES];
  int   total_reg, dma_end_reg, nrm_end_reg;
  int   zone_lo [3];
  int   zone_hi [3];
  int   zone_free [3];
  int   all_free, usable_cnt;
  zbpa_pkg::rsp_t pending_rsp [$];
  int   mismatches;
  int   cycles;
  int   span_pages;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int sat_dec(int c, int v);
    return (c > v) ? c - v : 0;
  endfunction

  function automatic int sat_inc(int c);
    return (c < int'(zbpa_pkg::CNT_MAX)) ? c + 1 : c;
  endfunction

  function automatic void set_zones();
    int t, d, n;
    t = (total_reg > zbpa_pkg::PAGES) ? zbpa_pkg::PAGES : total_reg;
    d = (dma_end_reg < t) ? dma_end_reg : t;
    n = (nrm_end_reg < t) ? nrm_end_reg : t;
    if (n < d) n = d;
    zone_lo[0] = 0; zone_hi[0] = d;
    zone_lo[1] = d; zone_hi[1] = n;
    zone_lo[2] = n; zone_hi[2] = t;
  endfunction

  function automatic int zone_of(longint p);
    for (int z = 0; z < 3; z++)
      if (p >= zone_lo[z] && p < zone_hi[z]) return z;
    return NO_ZONE;
  endfunction

  function automatic bit take_run(int z, int count, output int first);
    int run_len;
    first = 0;
    run_len = 0;
    if (count == 0 || zone_free[z] < count) return 1'b0;
    for (int i = zone_lo[z]; i < zone_hi[z]; i++) begin
      if (!page_used_q[i]) begin
        if (run_len == 0) first = i;
        run_len++;
        if (run_len == count) begin
          for (int k = 0; k < count; k++) page_used_q[first + k] = 1'b1;
          zone_free[z] = sat_dec(zone_free[z], count);
          all_free = sat_dec(all_free, count);
          return 1'b1;
        end
      end else begin
        run_len = 0;
      end
    end
    return 1'b0;
  endfunction

  function automatic zbpa_pkg::rsp_t allocator_response(zbpa_pkg::req_t r);
    zbpa_pkg::rsp_t o;
    int     got, count, changed, z;
    bit     ok;
    longint base, first_pg, end_pg, p;
    o = '0;
    changed = 0;
    count = int'(r.page_count);
    set_zones();
    case (r.cmd)
      zbpa_pkg::CMD_ALLOC: begin
        if (r.zone_sel == zbpa_pkg::ZSEL_ANY) begin
          ok = take_run(1, count, got);
          if (!ok) ok = take_run(2, count, got);
          if (!ok) ok = take_run(0, count, got);
        end else begin
          ok = take_run(int'(r.zone_sel), count, got);
        end
        if (ok) begin
          o.alloc_addr = 28'(longint'(got) << zbpa_pkg::PAGE_SHIFT);
          changed = count;
        end else begin
          o.status = 1'b1;
        end
      end
      zbpa_pkg::CMD_FREE: begin
        base = longint'(r.addr) >> zbpa_pkg::PAGE_SHIFT;
        for (int k = 0; k < count; k++) begin
          p = base + k;
          z = zone_of(p);
          if (z == NO_ZONE) o.bad_page_seen = 1'b1;
          else if (!page_used_q[p]) o.double_free_seen = 1'b1;
          else begin
            page_used_q[p] = 1'b0;
            zone_free[z] = sat_inc(zone_free[z]);
            all_free = sat_inc(all_free);
            changed = sat_inc(changed);
          end
        end
      end
      default: begin
        // free rounds inward, used rounds outward
        if (r.cmd == zbpa_pkg::CMD_MARK_FREE) begin
          first_pg = (longint'(r.addr) + PAGE_BYTES - 1) >> zbpa_pkg::PAGE_SHIFT;
          end_pg = (longint'(r.addr) + longint'(r.byte_size)) >> zbpa_pkg::PAGE_SHIFT;
        end else begin
          first_pg = longint'(r.addr) >> zbpa_pkg::PAGE_SHIFT;
          end_pg = (longint'(r.addr) + longint'(r.byte_size) + PAGE_BYTES - 1)
                   >> zbpa_pkg::PAGE_SHIFT;
        end
        if (end_pg > zone_hi[2]) end_pg = zone_hi[2];
        for (p = first_pg; p < end_pg; p++) begin
          z = zone_of(p);
          if (z == NO_ZONE) continue;
          if (r.cmd == zbpa_pkg::CMD_MARK_FREE && page_used_q[p]) begin
            page_used_q[p] = 1'b0;
            zone_free[z] = sat_inc(zone_free[z]);
            all_free = sat_inc(all_free);
            usable_cnt = sat_inc(usable_cnt);
            changed = sat_inc(changed);
          end else if (r.cmd == zbpa_pkg::CMD_MARK_USED && !page_used_q[p]) begin
            page_used_q[p] = 1'b1;
            zone_free[z] = sat_dec(zone_free[z], 1);
            all_free = sat_dec(all_free, 1);
            changed = sat_inc(changed);
          end
        end
      end
    endcase
    o.pages_changed = 17'(changed);
    o.free_total    = 17'(all_free);
    o.usable_total  = 17'(usable_cnt);
    o.free_dma      = 17'(zone_free[0]);
    o.free_normal   = 17'(zone_free[1]);
    o.free_high     = 17'(zone_free[2]);
    return o;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("mismatch %s: expected %0d got %0d", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    zbpa_pkg::rsp_t e;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) $display("response with no request pending");
      end else begin
        e = pending_rsp.pop_front();
        check_field("status", e.status, rsp.status);
        check_field("alloc_addr", e.alloc_addr, rsp.alloc_addr);
        check_field("pages_changed", e.pages_changed, rsp.pages_changed);
        check_field("bad_page_seen", e.bad_page_seen, rsp.bad_page_seen);
        check_field("double_free_seen", e.double_free_seen, rsp.double_free_seen);
        check_field("free_total", e.free_total, rsp.free_total);
        check_field("usable_total", e.usable_total, rsp.usable_total);
        check_field("free_dma", e.free_dma, rsp.free_dma);
        check_field("free_normal", e.free_normal, rsp.free_normal);
        check_field("free_high", e.free_high, rsp.free_high);
      end
    end
  end

  // Hold start high until an edge with busy low takes the request.
  task automatic send_request(zbpa_pkg::req_t r, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(allocator_response(r));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_zones(int t, int d, int n);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= zbpa_pkg::REG_TOTAL;   cfg_data <= 17'(t); @(posedge clk);
    cfg_idx <= zbpa_pkg::REG_DMA_END; cfg_data <= 17'(d); @(posedge clk);
    cfg_idx <= zbpa_pkg::REG_NRM_END; cfg_data <= 17'(n); @(posedge clk);
    cfg_we <= 1'b0;
    total_reg = t; dma_end_reg = d; nrm_end_reg = n;
    set_zones();
    span_pages = ((zone_hi[2] < 2048) ? zone_hi[2] : 2048) + 48;
  endtask

  function automatic zbpa_pkg::req_t make_req(logic [1:0] c, int a, int sz, int cnt,
                                              logic [1:0] zs);
    zbpa_pkg::req_t r;
    r.cmd = c; r.addr = 28'(a); r.byte_size = 29'(sz);
    r.page_count = 17'(cnt); r.zone_sel = zs;
    return r;
  endfunction

  function automatic int pick_gap(bit bursty);
    int g;
    g = $urandom_range(0, 19);
    if (bursty || g < 12) return 0;
    if (g < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic test_alloc_cases();
    // zero count
    send_request(make_req(zbpa_pkg::CMD_ALLOC, 0, 0, 0, zbpa_pkg::ZSEL_NRM), 0);
    // counter short
    send_request(make_req(zbpa_pkg::CMD_ALLOC, 0, 0, 1, zbpa_pkg::ZSEL_DMA), 2);
    send_request(make_req(zbpa_pkg::CMD_MARK_FREE, 0, 8 * PAGE_BYTES, 0,
                          zbpa_pkg::ZSEL_DMA), 0);
    // reversed region
    send_request(make_req(zbpa_pkg::CMD_MARK_FREE, 'h1800, 'h100, 0,
                          zbpa_pkg::ZSEL_DMA), 1);
    // run at page 0
    send_request(make_req(zbpa_pkg::CMD_ALLOC, 0, 0, 3, zbpa_pkg::ZSEL_DMA), 0);
    // falls to DMA
    send_request(make_req(zbpa_pkg::CMD_ALLOC, 0, 0, 2, zbpa_pkg::ZSEL_ANY), 5);
    send_request(make_req(zbpa_pkg::CMD_ALLOC, 0, 0, 1, zbpa_pkg::ZSEL_HIGH), 0);
    send_request(make_req(zbpa_pkg::CMD_ALLOC, 0, 0, 'h10000, zbpa_pkg::ZSEL_HIGH), 0);
  endtask

  task automatic test_free_cases();
    send_request(make_req(zbpa_pkg::CMD_FREE, 'h123, 0, 3, zbpa_pkg::ZSEL_DMA), 0);
    // double free
    send_request(make_req(zbpa_pkg::CMD_FREE, 0, 0, 6, zbpa_pkg::ZSEL_DMA), 3);
    // past the zones
    send_request(make_req(zbpa_pkg::CMD_FREE, 'hFFFF000, 0, 3, zbpa_pkg::ZSEL_DMA), 0);
    // zero count
    send_request(make_req(zbpa_pkg::CMD_FREE, 'h5000, 0, 0, zbpa_pkg::ZSEL_DMA), 0);
  endtask

  task automatic test_region_cases();
    send_request(make_req(zbpa_pkg::CMD_MARK_USED, 'h10, 'h1000, 0,
                          zbpa_pkg::ZSEL_DMA), 0);
    send_request(make_req(zbpa_pkg::CMD_MARK_USED, 'hFFFFFFF, 'h1FFFFFFF, 0,
                          zbpa_pkg::ZSEL_ANY), 0);
    send_request(make_req(zbpa_pkg::CMD_MARK_FREE, 0, 'h10000000, 0,
                          zbpa_pkg::ZSEL_DMA), 0);
    send_request(make_req(zbpa_pkg::CMD_ALLOC, 0, 0, 'h10000, zbpa_pkg::ZSEL_ANY), 0);
    send_request(make_req(zbpa_pkg::CMD_FREE, 0, 0, 'h10000, zbpa_pkg::ZSEL_DMA), 0);
    send_request(make_req(zbpa_pkg::CMD_MARK_USED, 0, 'h10000000, 0,
                          zbpa_pkg::ZSEL_DMA), 0);
    send_request(make_req(zbpa_pkg::CMD_MARK_FREE, 'h1001, 'h5000, 0,
                          zbpa_pkg::ZSEL_DMA), 0);
  endtask

  task automatic test_random(int n, bit bursty);
    zbpa_pkg::req_t r;
    int   pick, pg;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      pg = $urandom_range(0, span_pages);
      r = make_req(zbpa_pkg::CMD_ALLOC, 0, 0, 0, 2'($urandom_range(0, 3)));
      if (pick < 35) begin
        r.page_count = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 64))
                                                   : 17'($urandom_range(1, 8));
        r.addr = 28'($urandom);
      end else if (pick < 65) begin
        r.cmd = zbpa_pkg::CMD_FREE;
        r.addr = 28'((pg << zbpa_pkg::PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1));
        r.page_count = 17'($urandom_range(0, 16));
      end else begin
        r.cmd = (pick < 85) ? zbpa_pkg::CMD_MARK_FREE : zbpa_pkg::CMD_MARK_USED;
        r.addr = ($urandom_range(0, 1) == 0) ? 28'(pg << zbpa_pkg::PAGE_SHIFT)
                 : 28'((pg << zbpa_pkg::PAGE_SHIFT) + $urandom_range(0, PAGE_BYTES - 1));
        r.byte_size = ($urandom_range(0, 9) == 0) ? 29'($urandom_range(0, 64))
                      : 29'($urandom_range(0, 12 * PAGE_BYTES));
        r.page_count = 17'($urandom);
      end
      send_request(r, pick_gap(bursty));
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; req = '0;
    cfg_we = 1'b0; cfg_idx = zbpa_pkg::REG_TOTAL; cfg_data = '0;
    cycles = 0; mismatches = 0;
    for (int i = 0; i < zbpa_pkg::PAGES; i++) page_used_q[i] = 1'b1;
    zone_free = '{0, 0, 0};
    all_free = 0; usable_cnt = 0;
    total_reg = zbpa_pkg::PAGES; dma_end_reg = 4096; nrm_end_reg = zbpa_pkg::PAGES;
    set_zones();
    span_pages = 2048 + 48;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_alloc_cases();
    test_free_cases();
    test_region_cases();
    write_zones(1024, 256, 768);
    test_random(60, 1'b0);
    test_random(50, 1'b1);
    write_zones(512, 0, 512);
    test_random(50, 1'b0);
    write_zones(400, 400, 131071);
    test_random(40, 1'b0);
    write_zones(0, 0, 0);
    test_random(12, 1'b1);
    write_zones(300, 120, 60);
    test_random(30, 1'b0);
    write_zones(131071, 131071, 0);
    test_random(12, 1'b0);
    write_zones(2048, 700, 1500);
    test_random(20, 1'b0);

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
hdl/zbpa_pkg.sv
hdl/zoned_bitmap_page_allocator.sv
tb/zoned_bitmap_page_allocator_test.sv
